[hw/rtl/sha256_pkg.sv]
// Shared types, constants and round functions for the SHA-256 stream hasher.
// Used by the controller, the datapath and the top level; depends on nothing.
package sha256_pkg;

	localparam int LENGTH_BYTE_BITS = 61;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_LEN,
		ST_DBL,
		ST_OUT
	} state_t;

	// What the block buffer takes in a load cycle.
	typedef enum logic [1:0] {
		LD_NONE,
		LD_PAD,
		LD_LEN,
		LD_DBL
	} load_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic   take_byte;
		logic   clear_msg;
		logic   init_work;
		logic   round;
		logic   fold;
		load_t  load;
		logic   zero_buf;
		logic   second_iv;
		logic   restart;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       block_full;
		logic [5:0] fill;
		logic [5:0] round_cnt;
	} sts_t;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

[hw/rtl/sha256_ctrl.sv]
// Controller state machine for the SHA-256 stream hasher.
// Depends on sha256_pkg; drives datapath commands from its status.
module sha256_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_fire,
	input  logic                   in_has,
	input  logic                   in_last,
	input  logic                   double_hash,
	input  logic                   out_fire,
	input  logic [2:0]             out_idx,
	input  sha256_pkg::sts_t       sts,
	output sha256_pkg::cmd_t       cmd,
	output logic                   in_ready,
	output logic                   out_valid
);

	sha256_pkg::state_t state_q, state_d;
	// Which compression is running: 0 data, 1 pad, 2 length, 3 double.
	logic [1:0] phase_q, phase_d;
	logic       dbl_pend_q, dbl_pend_d;
	logic       last_q, last_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sha256_pkg::ST_IDLE;
			phase_q    <= 2'd0;
			dbl_pend_q <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			phase_q    <= phase_d;
			dbl_pend_q <= dbl_pend_d;
			last_q     <= last_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		dbl_pend_d = dbl_pend_q;
		last_d     = last_q;
		cmd        = '0;
		cmd.load   = sha256_pkg::LD_NONE;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.take_byte = in_has;
					last_d        = in_last;
					dbl_pend_d    = double_hash;
					if (in_has && sts.block_full) begin
						phase_d = 2'd0;
						state_d = sha256_pkg::ST_INIT;
					end else if (in_last) begin
						state_d = sha256_pkg::ST_PAD;
					end
				end
			end
			sha256_pkg::ST_INIT: begin
				// The second pass starts from the initial hash values.
				cmd.init_work = 1'b1;
				cmd.second_iv = (phase_q == 2'd3);
				state_d       = sha256_pkg::ST_ROUND;
			end
			sha256_pkg::ST_ROUND: begin
				cmd.round = 1'b1;
				if (sts.round_cnt == 6'd63)
					state_d = sha256_pkg::ST_FOLD;
			end
			sha256_pkg::ST_FOLD: begin
				cmd.fold = 1'b1;
				case (phase_q)
					2'd0: state_d = last_q ? sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
					2'd1: begin
						cmd.zero_buf = 1'b1;
						state_d      = sha256_pkg::ST_LEN;
					end
					2'd2: state_d = dbl_pend_q ? sha256_pkg::ST_DBL : sha256_pkg::ST_OUT;
					default: begin
						cmd.second_iv = 1'b1;
						state_d       = sha256_pkg::ST_OUT;
					end
				endcase
			end
			sha256_pkg::ST_PAD: begin
				cmd.load = sha256_pkg::LD_PAD;
				if (sts.fill >= 6'd56) begin
					phase_d = 2'd1;
					state_d = sha256_pkg::ST_INIT;
				end else begin
					state_d = sha256_pkg::ST_LEN;
				end
			end
			sha256_pkg::ST_LEN: begin
				cmd.load = sha256_pkg::LD_LEN;
				phase_d  = 2'd2;
				state_d  = sha256_pkg::ST_INIT;
			end
			sha256_pkg::ST_DBL: begin
				cmd.load = sha256_pkg::LD_DBL;
				phase_d  = 2'd3;
				state_d  = sha256_pkg::ST_INIT;
			end
			sha256_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_fire && out_idx == 3'd7) begin
					cmd.restart = 1'b1;
					last_d      = 1'b0;
					state_d     = sha256_pkg::ST_IDLE;
				end
			end
			default: state_d = sha256_pkg::ST_IDLE;
		endcase
	end

endmodule

[hw/rtl/sha256_dp.sv]
// Datapath of the SHA-256 stream hasher: block buffer, message schedule,
// working variables, chain value and length counter. Depends on sha256_pkg.
module sha256_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  sha256_pkg::cmd_t   cmd,
	input  logic [7:0]         data_byte,
	input  logic               out_fire,
	output sha256_pkg::sts_t   sts,
	output logic [31:0]        digest_word,
	output logic [2:0]         word_index
);

	logic [31:0] buf_q  [16];
	logic [31:0] work_q [8];
	logic [31:0] chain_q [8];
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic [sha256_pkg::LENGTH_BYTE_BITS-1:0] total_q;
	logic [63:0] bits;

	logic [3:0]  wi;
	logic [4:0]  sh;
	logic [31:0] w_cur, s0, s1, w_new, t1, t2, ea, aa;

	assign wi   = fill_q[5:2];
	assign sh   = 5'd24 - {fill_q[1:0], 3'b000};
	assign bits = {{(64 - sha256_pkg::LENGTH_BYTE_BITS){1'b0}}, total_q} << 3;

	assign sts.block_full = (fill_q == 6'd63);
	assign sts.fill       = fill_q;
	assign sts.round_cnt  = rnd_q;

	// Schedule: buffer acts as a 16-word shift line, word 0 is the oldest one.
	assign s0    = sha256_pkg::rotr(buf_q[1], 7) ^ sha256_pkg::rotr(buf_q[1], 18)
	             ^ (buf_q[1] >> 3);
	assign s1    = sha256_pkg::rotr(buf_q[14], 17) ^ sha256_pkg::rotr(buf_q[14], 19)
	             ^ (buf_q[14] >> 10);
	assign w_new = buf_q[0] + s0 + buf_q[9] + s1;
	assign w_cur = (rnd_q < 6'd16) ? buf_q[0] : w_new;

	// Round function.
	assign ea = work_q[4];
	assign aa = work_q[0];
	assign t1 = work_q[7] + (sha256_pkg::rotr(ea, 6) ^ sha256_pkg::rotr(ea, 11)
	          ^ sha256_pkg::rotr(ea, 25)) + ((ea & work_q[5]) ^ (~ea & work_q[6]))
	          + sha256_pkg::K[rnd_q] + w_cur;
	assign t2 = (sha256_pkg::rotr(aa, 2) ^ sha256_pkg::rotr(aa, 13)
	          ^ sha256_pkg::rotr(aa, 22))
	          + ((aa & work_q[1]) ^ (aa & work_q[2]) ^ (work_q[1] & work_q[2]));

	// Control counters and chain value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			total_q <= '0;
			rnd_q   <= '0;
			oidx_q  <= '0;
			for (int i = 0; i < 8; i++) chain_q[i] <= sha256_pkg::IV[i];
		end else begin
			if (cmd.take_byte) begin
				fill_q  <= fill_q + 6'd1;
				total_q <= total_q + 1'b1;
			end
			if (cmd.round) rnd_q <= rnd_q + 6'd1;
			if (cmd.fold) begin
				for (int i = 0; i < 8; i++) begin
					if (cmd.second_iv) chain_q[i] <= sha256_pkg::IV[i] + work_q[i];
					else               chain_q[i] <= chain_q[i] + work_q[i];
				end
			end
			if (out_fire) oidx_q <= oidx_q + 3'd1;
			if (cmd.restart) begin
				fill_q  <= '0;
				total_q <= '0;
				oidx_q  <= '0;
				for (int i = 0; i < 8; i++) chain_q[i] <= sha256_pkg::IV[i];
			end
		end
	end

	// Block buffer and working variables.
	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			if (fill_q[1:0] == 2'd0) buf_q[wi] <= {data_byte, 24'd0};
			else buf_q[wi] <= buf_q[wi] | ({24'd0, data_byte} << sh);
		end
		if (cmd.init_work) begin
			for (int i = 0; i < 8; i++)
				work_q[i] <= cmd.second_iv ? sha256_pkg::IV[i] : chain_q[i];
		end
		if (cmd.round) begin
			for (int i = 0; i < 15; i++) buf_q[i] <= buf_q[i + 1];
			buf_q[15] <= (rnd_q < 6'd16) ? buf_q[0] : w_new;
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
		if (cmd.zero_buf)
			for (int i = 0; i < 16; i++) buf_q[i] <= '0;
		case (cmd.load)
			sha256_pkg::LD_PAD: begin
				if (fill_q[1:0] == 2'd0) buf_q[wi] <= 32'h80000000;
				else buf_q[wi] <= (buf_q[wi] & ~((32'h100 << sh) - 32'd1))
				                | (32'h80 << sh);
				for (int i = 0; i < 16; i++)
					if (i > 32'(wi)) buf_q[i] <= '0;
			end
			sha256_pkg::LD_LEN: begin
				buf_q[14] <= bits[63:32];
				buf_q[15] <= bits[31:0];
			end
			sha256_pkg::LD_DBL: begin
				for (int i = 0; i < 8; i++) buf_q[i] <= chain_q[i];
				buf_q[8] <= 32'h80000000;
				for (int i = 9; i < 15; i++) buf_q[i] <= '0;
				buf_q[15] <= 32'd256;
			end
			default: ;
		endcase
	end

	assign digest_word = chain_q[oidx_q];
	assign word_index  = oidx_q;

endmodule

[hw/rtl/sha256_stream_hasher.sv]
// Top level of the SHA-256 stream hasher: APB register, controller, datapath.
// Depends on sha256_pkg, sha256_ctrl and sha256_dp.
//
// channel   direction  contents
// s_axis    in         tdata = data_byte; tuser = has_byte; tlast = last
// m_axis    out        tdata = digest_word; tuser = word_index; tlast = last_word
// apb       in         register 0 at address 0: double_hash
//
// A byte that neither fills a block nor ends the message leaves the block idle.
// A filled block adds a load of the working variables, 64 rounds of the single
// round unit and a fold; so do padding at a fill of 56 or more, the length block
// and a double pass. Digest words leave one per cycle while m_axis_tready holds.
// Reset restores the initial hash values and clears the length and fill.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] has_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,  // [2:0] word_index
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	sha256_pkg::cmd_t cmd;
	sha256_pkg::sts_t sts;
	logic             dbl_q;
	logic             in_fire, out_fire;

	assign pready = 1'b1;
	assign prdata = {31'd0, dbl_q};

	// Configuration register; only address zero is a register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbl_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == 1'b0) begin
			dbl_q <= pwdata[0];
		end
	end

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign m_axis_tlast = (m_axis_tuser == 3'd7);

	sha256_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.in_has      (s_axis_tuser),
		.in_last     (s_axis_tlast),
		.double_hash (dbl_q),
		.out_fire    (out_fire),
		.out_idx     (m_axis_tuser),
		.sts         (sts),
		.cmd         (cmd),
		.in_ready    (s_axis_tready),
		.out_valid   (m_axis_tvalid)
	);

	sha256_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (s_axis_tdata),
		.out_fire    (out_fire),
		.sts         (sts),
		.digest_word (m_axis_tdata),
		.word_index  (m_axis_tuser)
	);

endmodule

[hw/rtl/sha256_checker.sv]
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends only on the top level's ports.
module sha256_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// Input is never taken while a digest is on offer.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("input ready during output");

	// Word index steps by one on each accepted word.
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
		m_axis_tuser == $past(m_axis_tuser) + 3'd1) else $error("word index skipped");

	// Last word ends the burst and reopens the input.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
		!m_axis_tvalid && s_axis_tready) else $error("digest did not end");

	// A stalled word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled word changed");

endmodule

bind sha256_stream_hasher sha256_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

[bench/sha256_stream_hasher_checker.sv]
`timescale 1ns / 1ps
// Checker for the SHA-256 stream hasher: watches the byte stream, the digest stream
// and register writes, predicts every digest word and compares. Depends on sha256_pkg.
module sha256_stream_hasher_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          pending,
	output int          digests
);

	typedef logic [7:0][31:0]  hash_t;
	typedef logic [15:0][31:0] blk_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        lst;
	} digest_word_t;

	localparam logic [0:0] ADDR_DOUBLE_HASH = 1'b0;

	digest_word_t digest_q[$];
	hash_t        chain;
	blk_t         blk;
	logic [5:0]   fill;
	logic [sha256_pkg::LENGTH_BYTE_BITS-1:0] total;
	logic         dbl;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic hash_t initial_chain();
		hash_t h;
		for (int i = 0; i < 8; i++) h[i] = sha256_pkg::IV[i];
		return h;
	endfunction

	// One 64-round compression of a block into a chain value.
	function automatic hash_t compress(input hash_t h, input blk_t m);
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1, x15, x2;
		int r;
		for (int i = 0; i < 16; i++) w[i] = m[i];
		for (int i = 0; i < 8; i++) v[i] = h[i];
		for (int n = 0; n < 64; n++) begin
			r = n % 16;
			if (n >= 16) begin
				x15 = w[(r + 1) % 16];
				x2 = w[(r + 14) % 16];
				s0 = ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3);
				s1 = ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10);
				w[r] = w[r] + s0 + w[(r + 9) % 16] + s1;
			end
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::K[n] + w[r];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int i = 7; i > 0; i--) v[i] = v[i - 1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) h[i] = h[i] + v[i];
		return h;
	endfunction

	// Take one accepted word into the message; on the end of a message queue the digest.
	task automatic predict_digest(input logic [7:0] b, input logic has, input logic lst);
		int wi, sh;
		logic [31:0] mask;
		logic [63:0] bits;
		digest_word_t d;
		if (has) begin
			wi = fill[5:2];
			sh = 24 - 8 * fill[1:0];
			if (fill[1:0] == 2'd0) blk[wi] = {b, 24'h0};
			else blk[wi] = blk[wi] | (32'(b) << sh);
			total = total + 1'b1;
			fill = fill + 6'd1;
			if (fill == 6'd0) chain = compress(chain, blk);
		end
		if (!lst) return;
		// Padding marker, zeros, then the bit length.
		wi = fill[5:2];
		sh = 24 - 8 * fill[1:0];
		mask = (32'h100 << sh) - 32'd1;
		if (fill[1:0] == 2'd0) blk[wi] = 32'h8000_0000;
		else blk[wi] = (blk[wi] & ~mask) | (32'h80 << sh);
		for (int i = wi + 1; i < 16; i++) blk[i] = '0;
		if (fill >= 6'd56) begin
			chain = compress(chain, blk);
			blk = '0;
		end
		bits = {{(64 - sha256_pkg::LENGTH_BYTE_BITS){1'b0}}, total} << 3;
		blk[14] = bits[63:32];
		blk[15] = bits[31:0];
		chain = compress(chain, blk);
		// Second pass over the 32-byte digest.
		if (dbl) begin
			for (int i = 0; i < 8; i++) blk[i] = chain[i];
			blk[8] = 32'h8000_0000;
			for (int i = 9; i < 15; i++) blk[i] = '0;
			blk[15] = 32'd256;
			chain = compress(initial_chain(), blk);
		end
		for (int i = 0; i < 8; i++) begin
			d.word = chain[i];
			d.idx = 3'(i);
			d.lst = (i == 7);
			digest_q.push_back(d);
		end
		chain = initial_chain();
		fill = '0;
		total = '0;
	endtask

	// Watch all three ports, predict on input words and compare output words.
	always @(posedge clk or negedge arst_n) begin
		digest_word_t d;
		if (!arst_n) begin
			digest_q.delete();
			chain = initial_chain();
			blk = '0;
			fill = '0;
			total = '0;
			dbl = 1'b0;
			errors = 0;
			digests = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_DOUBLE_HASH)
				dbl = pwdata[0];
			if (s_axis_tvalid && s_axis_tready)
				predict_digest(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (digest_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected digest word %h index %0d last %b",
							$realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					d = digest_q.pop_front();
					if (d.lst) digests++;
					if (m_axis_tdata !== d.word || m_axis_tuser !== d.idx
						|| m_axis_tlast !== d.lst) begin
						errors++;
						if (errors <= 10)
							$display("%0t: digest word expected %h/%0d/%b got %h/%0d/%b",
								$realtime, d.word, d.idx, d.lst,
								m_axis_tdata, m_axis_tuser, m_axis_tlast);
					end
				end
			end
		end
		pending = digest_q.size();
	end

endmodule

[bench/sha256_stream_hasher_tb.sv]
`timescale 1ns / 1ps
// Top of the SHA-256 stream hasher bench: clock, reset, byte stimulus, register
// writes and the verdict. Depends on sha256_pkg, the block and the checker.
module sha256_stream_hasher_tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [0:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	localparam logic [0:0] ADDR_DOUBLE_HASH = 1'b0;

	int errors, pending, digests;
	int bytes_sent = 0;
	int messages = 0;
	bit calm = 1'b0;
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;
	int hold_cnt = 0;

	sha256_stream_hasher uut (.*);

	sha256_stream_hasher_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d digest words outstanding", pending);
		$display("simulation failed");
		$finish;
	end

	// Digest receiver: random stalls, one long hold-off on request.
	always @(negedge clk) begin
		if (hold_go && !hold_done) begin
			hold_done = 1'b1;
			hold_cnt = 600;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || $urandom_range(99) >= 18;
		end
	end

	// Offer one word and hold it until the block takes it.
	task automatic put_word(input logic [7:0] b, input logic has, input logic lst);
		while (!calm && $urandom_range(99) < 18) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= has;
		s_axis_tlast <= lst;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		if (has) bytes_sent++;
	endtask

	// One whole message of n bytes, with a few ignored words mixed in.
	task automatic send_message(input int n);
		bit end_on_byte;
		end_on_byte = (n > 0) && $urandom_range(1);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 8) put_word(8'($urandom), 1'b0, 1'b0);
			put_word(8'($urandom), 1'b1, end_on_byte && i == n - 1);
		end
		if (!end_on_byte) put_word(8'($urandom), 1'b0, 1'b1);
		messages++;
	endtask

	// Register write while the block is idle.
	task automatic write_double_hash(input logic v);
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (20) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_DOUBLE_HASH;
		pwdata <= {31'($urandom_range(32'h7fff_ffff)), v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Random messages until the byte budget for this setting is used.
	task automatic random_messages(input int budget);
		int stop;
		int n;
		int edge_len [6] = '{55, 56, 63, 64, 119, 120};
		stop = bytes_sent + budget;
		while (bytes_sent < stop) begin
			if ($urandom_range(9) < 2) n = edge_len[$urandom_range(5)];
			else n = $urandom_range(20);
			send_message(n);
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_double_hash(1'b0);

		// Directed: empty message, ignored words, extreme bytes, end on a byte.
		put_word(8'hff, 1'b0, 1'b1);
		put_word(8'hff, 1'b0, 1'b0);
		put_word(8'h61, 1'b1, 1'b0);
		put_word(8'h62, 1'b1, 1'b0);
		put_word(8'h63, 1'b1, 1'b1);
		put_word(8'hff, 1'b1, 1'b1);
		put_word(8'h00, 1'b1, 1'b0);
		put_word(8'h00, 1'b0, 1'b0);
		put_word(8'h55, 1'b0, 1'b1);
		put_word(8'haa, 1'b1, 1'b1);
		messages += 5;

		// Double mode, with a long receiver stall while messages keep coming, then single mode.
		write_double_hash(1'b1);
		hold_go = 1'b1;
		random_messages(20);
		write_double_hash(1'b0);
		random_messages(20);

		// Pause until every digest is out, then a stretch with no idling.
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		calm = 1'b1;
		write_double_hash(1'b1);
		random_messages(20);
		calm = 1'b0;

		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (200) @(posedge clk);
		$display("%0d messages, %0d message bytes, %0d digests checked in single and double mode",
			messages, bytes_sent, digests);
		if (errors == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", errors);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_ctrl.sv
hw/rtl/sha256_dp.sv
hw/rtl/sha256_stream_hasher.sv
hw/rtl/sha256_checker.sv
bench/sha256_stream_hasher_checker.sv
bench/sha256_stream_hasher_tb.sv
